>>> design/assert_macros.svh
// Assertion helpers shared by sa_front and sa_div_pipe.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define SA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sa assertion failed");

// Next-cycle implication, gated off during reset.
`define SA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sa assertion failed");

`endif

>>> design/sa_pkg.sv
package sa_pkg;

    localparam int DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Request as it travels down the pipeline.
    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] quo;      // result, or quotient so far
        logic [DATA_WIDTH-1:0] rem;      // partial remainder (zero unless divide)
        logic [DATA_WIDTH-1:0] divisor;
    } sa_item_t;

endpackage

>>> design/sa_front.sv
`include "assert_macros.svh"

module sa_front
    import sa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  op_t                   in_op,
    input  logic [DATA_WIDTH-1:0] in_a,
    input  logic [DATA_WIDTH-1:0] in_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sa_item_t              out_item
);

    logic     valid_reg;
    sa_item_t item_reg;
    sa_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next.op      = in_op;
        item_next.divisor = in_b;
        item_next.rem     = '0;
        unique case (in_op)
            OP_ADD: item_next.quo = in_a + in_b;
            OP_SUB: item_next.quo = in_a + (~in_b + DATA_WIDTH'(1));
            OP_MUL: item_next.quo = in_a * in_b;
            OP_DIV: begin
                item_next.quo = '0;
                item_next.rem = in_a;
            end
            default: item_next.quo = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    `SA_ASSERT_NEXT(a_add_sum, in_valid && in_ready && in_op == OP_ADD,
        item_reg.quo == $past(in_a + in_b))
    `SA_ASSERT_IMPL(a_front_rem_zero, valid_reg && item_reg.op != OP_DIV, item_reg.rem == '0)

endmodule

>>> design/sa_div_pipe.sv
`include "assert_macros.svh"

module sa_div_pipe
    import sa_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  sa_item_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output sa_item_t out_item
);

    logic     valid_reg [DATA_WIDTH];
    sa_item_t item_reg  [DATA_WIDTH];
    logic     stage_ready [DATA_WIDTH+1];

    assign stage_ready[DATA_WIDTH] = out_ready;
    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[DATA_WIDTH-1];
    assign out_item  = item_reg[DATA_WIDTH-1];

    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
        localparam int BIT = DATA_WIDTH - 1 - k;

        logic                  src_valid;
        sa_item_t              src;
        sa_item_t              item_next;
        logic [DATA_WIDTH:0]   diff;
        logic [DATA_WIDTH-1:0] low_mask;

        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src       = in_item;
        end else begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src       = item_reg[k-1];
        end

        assign stage_ready[k] = !valid_reg[k] || stage_ready[k+1];

        // One restoring step: try subtracting divisor at this bit position.
        always_comb begin
            low_mask  = (DATA_WIDTH'(1) << BIT) - DATA_WIDTH'(1);
            diff      = {1'b0, src.rem >> BIT} - {1'b0, src.divisor};
            item_next = src;
            if (src.op == OP_DIV && !diff[DATA_WIDTH]) begin
                item_next.quo = src.quo | (DATA_WIDTH'(1) << BIT);
                item_next.rem = (diff[DATA_WIDTH-1:0] << BIT) | (src.rem & low_mask);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (stage_ready[k]) begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_ready[k] && src_valid) begin
                item_reg[k] <= item_next;
            end
        end
    end

    `SA_ASSERT_IMPL(a_rem_below_divisor,
        out_valid && out_item.op == OP_DIV && out_item.divisor != '0,
        out_item.rem < out_item.divisor)
    `SA_ASSERT_IMPL(a_div_zero_ones,
        out_valid && out_item.op == OP_DIV && out_item.divisor == '0,
        out_item.quo == '1)
    `SA_ASSERT_IMPL(a_other_rem_zero, out_valid && out_item.op != OP_DIV,
        out_item.rem == '0)

endmodule

>>> design/shift_add_arithmetic_unit.sv
// Integer arithmetic unit: add, subtract, multiply (low word) and unsigned
// restoring divide on 32-bit operands, with no state carried between requests.
// Input channel s_*: one request per s_valid/s_ready handshake carries
// s_operation (0 add, 1 subtract, 2 multiply, 3 divide), s_operand_a and
// s_operand_b. Result channel m_*: one item per request, in request order,
// carries m_result (sum, difference, low product or quotient) and
// m_remainder (divide remainder, zero otherwise). Divide by zero returns an
// all-ones quotient and the dividend as remainder.
// A request passes one operand stage holding the adder and multiplier,
// then 32 divide stages, one quotient bit each.
// Throughput: one request per cycle unless the receiver stalls; every op
// flows through all stages.
// Reset (aresetn low, synchronous) empties the pipeline; no result pending.
// When the receiver stalls, the last stage holds its result and the stages
// behind it keep filling bubbles, so s_ready drops only once every stage
// holds a request.
module shift_add_arithmetic_unit
    import sa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [DATA_WIDTH-1:0] s_operand_a,
    input  logic [DATA_WIDTH-1:0] s_operand_b,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_result,
    output logic [DATA_WIDTH-1:0] m_remainder
);

    logic     front_valid;
    logic     front_ready;
    sa_item_t front_item;
    sa_item_t tail_item;

    // Operand stage: add, subtract and multiply finish here; divide loads
    // the dividend as the starting partial remainder.
    sa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_op     (op_t'(s_operation)),
        .in_a      (s_operand_a),
        .in_b      (s_operand_b),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // Divide stages: other ops pass through unchanged to keep order.
    sa_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (tail_item)
    );

    assign m_result    = tail_item.quo;
    assign m_remainder = tail_item.rem;

endmodule

>>> verif/tb_shift_add_arithmetic_unit.sv
module tb_shift_add_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sa_pkg::*;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct {
        word_t quo;
        word_t rem;
    } alu_out_t;

    // Holds the results still owed by the unit, oldest first.
    class alu_scoreboard;
        alu_out_t pending_q[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        // Restoring divide, top bit down; a zero divisor sets every bit.
        function automatic alu_out_t compute(op_t op, word_t a, word_t b);
            alu_out_t o;
            logic [2*DATA_WIDTH-1:0] r;
            o.quo = '0;
            o.rem = '0;
            case (op)
                OP_ADD: o.quo = a + b;
                OP_SUB: o.quo = a + (~b + word_t'(1));
                OP_MUL: o.quo = a * b;
                OP_DIV: begin
                    r = {{DATA_WIDTH{1'b0}}, a};
                    for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
                        if ((r >> i) >= {{DATA_WIDTH{1'b0}}, b}) begin
                            o.quo[i] = 1'b1;
                            r = r - ({{DATA_WIDTH{1'b0}}, b} << i);
                        end
                    end
                    o.rem = r[DATA_WIDTH-1:0];
                end
            endcase
            return o;
        endfunction

        function void note_request(op_t op, word_t a, word_t b);
            pending_q.push_back(compute(op, a, b));
        endfunction

        function void check_result(word_t res, word_t rem);
            alu_out_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h/%h", $time, res, rem);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (res !== e.quo) begin
                $display("%0t: result exp %h got %h", $time, e.quo, res);
                errors++;
            end
            if (rem !== e.rem) begin
                $display("%0t: remainder exp %h got %h", $time, e.rem, rem);
                errors++;
            end
        endfunction
    endclass

    logic  aclk = 1'b0;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    logic  [1:0] s_operation = '0;
    word_t s_operand_a = '0;
    word_t s_operand_b = '0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    word_t m_result;
    word_t m_remainder;

    alu_scoreboard sb = new();
    bit    quiet_phase = 1'b0;   // no idling in the closing stretch
    bit    hold_sink = 1'b0;     // long receiver stall, set by the sender
    bit    stim_done = 1'b0;

    always #5 aclk = ~aclk;

    shift_add_arithmetic_unit u_top (.*);

    // Check every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result, m_remainder);
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin : sink
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (120) @(posedge aclk);
                hold_sink = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 18);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Offer one request and hold it until accepted; note it at acceptance.
    task automatic send_request(op_t op, word_t a, word_t b);
        int n;
        if (!quiet_phase && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, a, b);
    endtask

    // Random operand with a bias toward the edges of the range.
    function automatic word_t pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return word_t'($urandom_range(0, 15));
            3: return {1'b1, {(DATA_WIDTH-1){1'b0}}};
            4: return $urandom >> $urandom_range(0, DATA_WIDTH - 1);
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        op_t   op;
        word_t b;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of every operation, wrap, divide by zero.
        for (int k = 0; k < 4; k++) begin
            op = op_t'(k);
            send_request(op, '0, '0);
            send_request(op, '1, '1);
            send_request(op, '1, 32'd1);
            send_request(op, 32'h8000_0000, 32'h7fff_ffff);
            send_request(op, 32'h1234_5678, '0);
        end
        send_request(OP_DIV, 32'd7, 32'd9);
        send_request(OP_DIV, 32'hdead_beef, 32'h8000_0001);

        // Random part; the long receiver stall fires partway through.
        for (int i = 0; i < 628; i++) begin
            if (i == 200) hold_sink = 1'b1;
            if (i == 560) quiet_phase = 1'b1;
            op = op_t'($urandom_range(0, 3));
            b  = pick_operand();
            if (op == OP_DIV && $urandom_range(0, 3) != 0 && b > 32'hffff)
                b = b >> $urandom_range(8, 28);
            send_request(op, pick_operand(), b);
        end
        s_valid <= 1'b0;

        // Drain, then leave the pipeline latency to flush stray results.
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule
